// ===== hdl/lct_pkg.sv =====
// lct_pkg: word types, sweep token, commit broadcast and sequencer states
// for the lfu cache table; no dependencies
`timescale 1ns / 1ps

package lct_pkg;

  localparam int IDX_W   = 8;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int CAP_RESET = 16;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // token handed from cell to cell during a sweep
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  hit_rank;
    logic [DATA_W-1:0] hit_value;
    logic              vic_have;
    logic [DATA_W-1:0] vic_uses;
    logic [IDX_W-1:0]  vic_rank;
    logic [IDX_W-1:0]  vic_idx;
    logic [DATA_W-1:0] vic_key;
    logic              free_have;
    logic [IDX_W-1:0]  free_idx;
  } tok_t;

  // update broadcast to every cell at the end of an operation
  typedef struct packed {
    logic              touch;
    logic              write;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  old_rank;
    logic              evict;
    logic [IDX_W-1:0]  vic_idx;
    logic [IDX_W-1:0]  vic_rank;
    logic              insert;
    logic [IDX_W-1:0]  ins_idx;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } cmt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_COMMIT
  } state_t;

endpackage

// ===== hdl/lct_cell.sv =====
// lct_cell: one table entry with its part of the lookup and victim sweep
// depends on lct_pkg
`timescale 1ns / 1ps

module lct_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lct_pkg::DATA_W-1:0]  key,
  input  lct_pkg::tok_t               tok_in,
  output lct_pkg::tok_t               tok_out,
  input  lct_pkg::cmt_t               cmt
);
  import lct_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic              valid;
  logic [DATA_W-1:0] ekey;
  logic [DATA_W-1:0] evalue;
  logic [DATA_W-1:0] uses;
  logic [IDX_W-1:0]  rank;
  tok_t              tok_next;

  always_comb begin
    tok_next = tok_in;
    if (valid && ekey == key && !tok_in.hit) begin
      tok_next.hit       = 1'b1;
      tok_next.hit_idx   = MY_IDX;
      tok_next.hit_rank  = rank;
      tok_next.hit_value = evalue;
    end
    // lowest count wins, oldest on a tie
    if (valid && (!tok_in.vic_have || uses < tok_in.vic_uses ||
                  (uses == tok_in.vic_uses && rank > tok_in.vic_rank))) begin
      tok_next.vic_have = 1'b1;
      tok_next.vic_uses = uses;
      tok_next.vic_rank = rank;
      tok_next.vic_idx  = MY_IDX;
      tok_next.vic_key  = ekey;
    end
    if (!valid && !tok_in.free_have) begin
      tok_next.free_have = 1'b1;
      tok_next.free_idx  = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmt.touch) begin
      if (cmt.hit_idx == MY_IDX) begin
        if (uses != {DATA_W{1'b1}}) begin
          uses <= uses + DATA_W'(1);
        end
        rank <= '0;
        if (cmt.write) begin
          evalue <= cmt.value;
        end
      end else if (valid && rank < cmt.old_rank) begin
        rank <= rank + IDX_W'(1);
      end
    end else if (cmt.insert) begin
      if (cmt.ins_idx == MY_IDX) begin
        valid  <= 1'b1;
        ekey   <= cmt.key;
        evalue <= cmt.value;
        uses   <= DATA_W'(1);
        rank   <= '0;
      end else if (cmt.evict && cmt.vic_idx == MY_IDX) begin
        valid <= 1'b0;
      end else if (valid) begin
        // close the victim's gap, then age behind the new entry
        if (cmt.evict && rank > cmt.vic_rank) begin
          rank <= rank;
        end else begin
          rank <= rank + IDX_W'(1);
        end
      end
    end
  end

endmodule

// ===== hdl/lfu_cache_table_top.sv =====
// lfu_cache_table_top: sequencer, configuration register and cell chain
// depends on lct_pkg and lct_cell
`timescale 1ns / 1ps

// channel  dir  handshake              word
// req      in   req_valid/req_stall    lct_pkg::req_t
// rsp      out  rsp_valid/rsp_stall    lct_pkg::rsp_t
// cfg      in   cfg_valid/cfg_ready    capacity_limit, 5 bits
//
// each operation sweeps then commits: the token walks the cell chain,
// one cell a cycle, then a commit updates every cell at once
// the result register holds until taken; a stalled result holds the commit
// synchronous reset clears all valid bits at once, capacity returns to 16

module lfu_cache_table_top #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  lct_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output lct_pkg::rsp_t              rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lct_pkg::CAP_W-1:0]  cfg_data
);
  import lct_pkg::*;

  localparam int CW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int WW = 10;

  state_t           state, state_next;
  logic [CW-1:0]    cnt;
  logic [OW-1:0]    occupied;
  logic [CAP_W-1:0] capacity;
  req_t             op;
  tok_t             chain [ENTRIES+1];
  tok_t             tok;
  cmt_t             cmt;
  logic             accept, rsp_free, commit;
  logic [WW-1:0]    cap_eff, occ_w;
  logic             miss_put, evict, insert, cap_zero;
  rsp_t             rsp_next;

  assign cfg_ready = 1'b1;
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_valid) state_next = ST_SWEEP;
      ST_SWEEP:  if (cnt == CW'(ENTRIES - 1)) state_next = ST_COMMIT;
      ST_COMMIT: if (rsp_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    commit    = 1'b0;
    unique case (state)
      ST_IDLE:   req_stall = 1'b0;
      ST_SWEEP:  req_stall = 1'b1;
      ST_COMMIT: commit = rsp_free;
      default:   req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        cnt <= cnt + CW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= req;
    end
  end

  assign chain[0] = '0;
  assign tok      = chain[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lct_cell #(.CELL_INDEX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .key     (op.lookup_key),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .cmt     (cmt)
    );
  end

  always_comb begin
    cap_eff  = ({5'b0, capacity} > WW'(ENTRIES)) ? WW'(ENTRIES) : {5'b0, capacity};
    occ_w    = WW'(occupied);
    cap_zero = (cap_eff == '0);
    miss_put = (op.kind == KIND_PUT) && !cap_zero && !tok.hit;
    evict    = miss_put && (occ_w >= cap_eff) && tok.vic_have;
    insert   = miss_put && (evict || tok.free_have);

    cmt          = '0;
    cmt.touch    = commit && tok.hit && (op.kind == KIND_GET || !cap_zero);
    cmt.write    = (op.kind == KIND_PUT);
    cmt.hit_idx  = tok.hit_idx;
    cmt.old_rank = tok.hit_rank;
    cmt.evict    = evict;
    cmt.vic_idx  = tok.vic_idx;
    cmt.vic_rank = tok.vic_rank;
    cmt.insert   = commit && insert;
    if (evict) begin
      cmt.ins_idx = (tok.free_have && tok.free_idx < tok.vic_idx) ? tok.free_idx
                                                                  : tok.vic_idx;
    end else begin
      cmt.ins_idx = tok.free_idx;
    end
    cmt.key   = op.lookup_key;
    cmt.value = op.write_value;

    rsp_next.hit         = tok.hit;
    rsp_next.read_value  = (op.kind == KIND_GET && tok.hit) ? tok.hit_value : -32'sd1;
    rsp_next.evicted     = evict;
    rsp_next.evicted_key = evict ? tok.vic_key : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else if (commit) begin
      occupied <= occupied + OW'(insert) - OW'(evict);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking regression for lfu_cache_table_top
// depends on lct_pkg and the cache table rtl
`timescale 1ns / 1ps

module testbench;
  import lct_pkg::*;

  localparam int NENT = 16;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  lfu_cache_table_top #(.ENTRIES(NENT)) u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the table
  logic        sh_valid [NENT];
  logic [31:0] sh_key   [NENT];
  logic [31:0] sh_value [NENT];
  logic [31:0] sh_uses  [NENT];
  int unsigned sh_rank  [NENT];
  int unsigned sh_occ;
  int unsigned sh_cap;

  rsp_t pending_rsp[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_rsp = 1'b0;
  int rsp_gap_max = 3;
  logic [31:0] key_pool[8];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void bump_recent(int e);
    for (int i = 0; i < NENT; i++)
      if (sh_valid[i] && i != e && sh_rank[i] < sh_rank[e]) sh_rank[i]++;
    sh_rank[e] = 0;
    if (sh_uses[e] != 32'hFFFF_FFFF) sh_uses[e]++;
  endfunction

  function automatic rsp_t lfu_predict(req_t r);
    rsp_t o;
    int e, vic, slot;
    int unsigned cap, vr;
    cap = (sh_cap < NENT) ? sh_cap : NENT;
    o = '0;
    o.read_value = -1;
    e = -1;
    for (int i = 0; i < NENT; i++)
      if (e < 0 && sh_valid[i] && sh_key[i] == r.lookup_key) e = i;
    o.hit = (e >= 0);
    if (r.kind == KIND_GET) begin
      if (e >= 0) begin
        o.read_value = sh_value[e];
        bump_recent(e);
      end
    end else if (cap != 0) begin
      if (e >= 0) begin
        sh_value[e] = r.write_value;
        bump_recent(e);
      end else begin
        if (sh_occ >= cap) begin
          vic = -1;
          for (int i = 0; i < NENT; i++)
            if (sh_valid[i] && (vic < 0 || sh_uses[i] < sh_uses[vic] ||
                (sh_uses[i] == sh_uses[vic] && sh_rank[i] > sh_rank[vic])))
              vic = i;
          if (vic >= 0) begin
            vr = sh_rank[vic];
            o.evicted = 1'b1;
            o.evicted_key = sh_key[vic];
            sh_valid[vic] = 1'b0;
            sh_occ--;
            for (int i = 0; i < NENT; i++)
              if (sh_valid[i] && sh_rank[i] > vr) sh_rank[i]--;
          end
        end
        slot = -1;
        for (int i = 0; i < NENT; i++)
          if (slot < 0 && !sh_valid[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < NENT; i++)
            if (sh_valid[i]) sh_rank[i]++;
          sh_valid[slot] = 1'b1;
          sh_key[slot] = r.lookup_key;
          sh_value[slot] = r.write_value;
          sh_uses[slot] = 1;
          sh_rank[slot] = 0;
          sh_occ++;
        end
      end
    end
    return o;
  endfunction

  function automatic int pick_gap(int lim);
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, lim);
    return $urandom_range(0, 3);
  endfunction

  // result side: stretches of stall between ready cycles
  initial begin
    int g;
    g = 0;
    forever begin
      @(negedge clk);
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (rsp_gap_max == 0) rsp_stall <= 1'b0;
      else if (g > 0) begin
        rsp_stall <= 1'b1;
        g--;
      end else begin
        rsp_stall <= 1'b0;
        g = pick_gap(40);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t x;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        x = pending_rsp.pop_front();
        if (rsp.hit !== x.hit) begin
          $error("hit exp %0d got %0d", x.hit, rsp.hit); errors++;
        end
        if (rsp.read_value !== x.read_value) begin
          $error("read_value exp %0d got %0d", x.read_value, rsp.read_value); errors++;
        end
        if (rsp.evicted !== x.evicted) begin
          $error("evicted exp %0d got %0d", x.evicted, rsp.evicted); errors++;
        end
        if (rsp.evicted_key !== x.evicted_key) begin
          $error("evicted_key exp %0d got %0d", x.evicted_key, rsp.evicted_key);
          errors++;
        end
      end
    end
  end

  task automatic send_op(logic k, logic [31:0] key, logic [31:0] val, bit gaps = 1);
    int g;
    g = gaps ? pick_gap(30) : 0;
    // valid drops at the previous falling edge, so always wait for a falling edge
    repeat (g + 1) @(negedge clk);
    req_valid <= 1'b1;
    req <= '{kind: k, lookup_key: key, write_value: val};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp.push_back(lfu_predict('{kind: k, lookup_key: key, write_value: val}));
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (NENT + 8) @(posedge clk);
  endtask

  task automatic write_capacity(int unsigned c);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c[CAP_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sh_cap = c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_op(KIND_GET, 32'h8000_0000, 0);
    send_op(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(KIND_GET, 32'h7FFF_FFFF, 0);
    send_op(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(KIND_PUT, 32'h0, 32'h0);
    send_op(KIND_GET, 32'hFFFF_FFFF, 0);
    // fill to the full table then force lfu evictions with lru tie break
    for (int i = 0; i < 16; i++) send_op(KIND_PUT, 100 + i, i);
    send_op(KIND_GET, 32'h8000_0000, 0);
  endtask

  task automatic test_capacity_edges();
    write_capacity(0);
    // zero capacity: puts do nothing, gets still see held entries
    send_op(KIND_PUT, 32'h1234, 5);
    send_op(KIND_PUT, 105, 9);
    send_op(KIND_GET, 105, 0);
    write_capacity(31);
    for (int i = 0; i < 6; i++) send_op(KIND_PUT, 200 + i, i);
    write_capacity(3);
    // lowered below occupancy: one eviction per insert
    for (int i = 0; i < 5; i++) send_op(KIND_PUT, 300 + i, i);
    write_capacity(1);
    send_op(KIND_PUT, 400, 1);
    send_op(KIND_PUT, 401, 2);
  endtask

  task automatic run_random(int n, int unsigned cap, bit wide);
    logic [31:0] k;
    write_capacity(cap);
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      if (wide || $urandom_range(0, 9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, 7)] + $urandom_range(0, cap + 4);
      send_op(1'($urandom_range(0, 1)), k, $urandom);
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_rsp = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_op(1'($urandom_range(0, 1)), $urandom_range(0, 20),
                                           $urandom, 0);
    join
    drain();
    rsp_gap_max = 0;
    for (int i = 0; i < 60; i++) send_op(1'($urandom_range(0, 1)), $urandom_range(0, 20),
                                         $urandom, 0);
    rsp_gap_max = 3;
  endtask

  initial begin
    for (int i = 0; i < NENT; i++) begin
      sh_valid[i] = 0; sh_key[i] = 0; sh_value[i] = 0; sh_uses[i] = 0; sh_rank[i] = 0;
    end
    sh_occ = 0;
    sh_cap = CAP_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_capacity_edges();
    run_random(500, 16, 0);
    run_random(300, 5, 0);
    run_random(150, 31, 1);
    test_backpressure();
    run_random(350, 8, 0);
    run_random(80, 0, 0);
    run_random(250, 2, 0);
    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
